// ----- hdl/bdq_pkg.sv -----
`timescale 1ns / 1ps

package bdq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int OP_W     = 2;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request
      logic exec;     // perform operation on ring
   } cmd_type;

endpackage

// ----- hdl/bdq_ctrl.sv -----
`timescale 1ns / 1ps

module bdq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_strobe,
   output bdq_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_RESP);
   assign cmd.load   = (state_ff == ST_IDLE) && start;
   assign cmd.exec   = (state_ff == ST_EXEC);

endmodule

// ----- hdl/bdq_dpath.sv -----
`timescale 1ns / 1ps

module bdq_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  bdq_pkg::cmd_type                    cmd,
   input  logic [bdq_pkg::OP_W-1:0]            req_operation,
   input  logic signed [bdq_pkg::WORD_W-1:0]   req_value_in,
   output logic signed [bdq_pkg::WORD_W-1:0]   rsp_value_out,
   output logic [bdq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [bdq_pkg::CNT_W-1:0]           rsp_entry_count,
   output logic                                rsp_is_empty
);

   localparam int IW = bdq_pkg::IDX_W;
   localparam int CW = bdq_pkg::CNT_W;
   localparam int WW = bdq_pkg::WORD_W;

   logic [WW-1:0] mem [bdq_pkg::DEPTH];

   bdq_pkg::op_type         op_ff;
   logic [WW-1:0]           value_ff;
   logic [IW-1:0]           head_ff, head_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [WW-1:0]           rd_data_ff;
   logic                    pop_ok_ff;
   bdq_pkg::status_type     status_ff, status_in;

   logic          is_push, full, empty, do_write, pop_ok;
   logic [IW-1:0] head_dec, head_inc, tail_idx, last_idx, wr_addr, rd_addr;
   logic [CW:0]   tail_sum, last_sum;

   // one conditional subtract: head plus count stays below twice the depth
   function automatic logic [IW-1:0] ring_wrap(input logic [CW:0] x);
      logic [CW:0] y;
      y = (x >= (CW+1)'(bdq_pkg::DEPTH)) ? x - (CW+1)'(bdq_pkg::DEPTH) : x;
      return y[IW-1:0];
   endfunction

   always_comb begin
      is_push  = (op_ff == bdq_pkg::OP_PUSH_FRONT) || (op_ff == bdq_pkg::OP_PUSH_BACK);
      full     = (count_ff == CW'(bdq_pkg::DEPTH));
      empty    = (count_ff == '0);
      head_dec = (head_ff == '0) ? IW'(bdq_pkg::DEPTH - 1) : head_ff - 1'b1;
      head_inc = (head_ff == IW'(bdq_pkg::DEPTH - 1)) ? '0 : head_ff + 1'b1;
      tail_sum = (CW+1)'(head_ff) + {1'b0, count_ff};
      last_sum = tail_sum - 1'b1;
      tail_idx = ring_wrap(tail_sum);
      last_idx = ring_wrap(last_sum);
      wr_addr  = (op_ff == bdq_pkg::OP_PUSH_FRONT) ? head_dec : tail_idx;
      rd_addr  = (op_ff == bdq_pkg::OP_POP_FRONT) ? head_ff : last_idx;
      do_write = cmd.exec && is_push && !full;
      pop_ok   = !is_push && !empty;

      head_in   = head_ff;
      count_in  = count_ff;
      status_in = status_ff;
      if (cmd.exec) begin
         status_in = bdq_pkg::STATUS_OK;
         if (is_push) begin
            if (full) begin
               status_in = bdq_pkg::STATUS_OVERFLOW;
            end else begin
               count_in = count_ff + 1'b1;
               if (op_ff == bdq_pkg::OP_PUSH_FRONT) head_in = head_dec;
            end
         end else begin
            if (empty) begin
               status_in = bdq_pkg::STATUS_UNDERFLOW;
            end else begin
               count_in = count_ff - 1'b1;
               if (op_ff == bdq_pkg::OP_POP_FRONT) head_in = head_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         status_ff <= bdq_pkg::STATUS_OK;
         pop_ok_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         status_ff <= status_in;
         if (cmd.exec) pop_ok_ff <= pop_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= bdq_pkg::op_type'(req_operation);
         value_ff <= req_value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) mem[wr_addr] <= value_ff;
      if (cmd.exec) rd_data_ff <= mem[rd_addr];
   end

   assign rsp_value_out   = pop_ok_ff ? rd_data_ff : '0;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_is_empty    = (count_ff == '0);

endmodule

// ----- hdl/bounded_deque_top.sv -----
`timescale 1ns / 1ps

// Double-ended queue of signed 32-bit words on a 16-entry ring buffer. Raise
// start with an operation while busy is low; each operation runs through
// capture, ring update with the buffer read, and result (a separate step as
// the buffer read is registered); start is ignored while busy. The result
// appears on the rsp_ ports for exactly one cycle with rsp_strobe high and
// cannot be held off, so the receiver must take it in that cycle. A push to a
// full queue reports overflow and a pop from an empty one reports underflow;
// both leave the queue unchanged and return zero.

module bounded_deque_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [bdq_pkg::OP_W-1:0]            req_operation,
   input  logic signed [bdq_pkg::WORD_W-1:0]   req_value_in,
   output logic                                rsp_strobe,
   output logic signed [bdq_pkg::WORD_W-1:0]   rsp_value_out,
   output logic [bdq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [bdq_pkg::CNT_W-1:0]           rsp_entry_count,
   output logic                                rsp_is_empty
);

   bdq_pkg::cmd_type cmd;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   bdq_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_operation   (req_operation),
      .req_value_in    (req_value_in),
      .rsp_value_out   (rsp_value_out),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule
